// ===== rtl/lmt_pkg.sv =====
// ----------------------------------------------------------------------------
// lmt_pkg
// Shared types and constants of the local mean threshold block: register map,
// register widths and the control word that travels with a pixel beat.
// ----------------------------------------------------------------------------
`default_nettype none

package lmt_pkg;

   // configuration port geometry
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   // register map, as register indexes (byte address = 4 * index)
   localparam logic [0:0] REG_SIDE_LENGTH = 1'b0;

   // side_length register
   localparam int SIDE_W     = 13;
   localparam int SIDE_RESET = 2000;

   // control word carried with a beat from the input stage to the window stage
   typedef struct packed {
      logic emit;    // beat produces a result
      logic drain;   // frame pixels all in; beat carries no pixel
   } lmt_ctl_type;

endpackage

`default_nettype wire

// ===== rtl/local_mean_threshold_3x3.sv =====
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3
// Adaptive mean threshold over a clipped 3x3 neighbourhood of a raster image.
// ----------------------------------------------------------------------------
// Takes one pixel beat per clock and gives one result per clock while the
// result channel does not stall; the result of a completed window is behind
// one line-store read and one window stage. The result for a pixel comes with
// the beat N+1 positions later, so the first N+1 beats of a frame give no
// result and the frame is drained by N+1 padding beats after the N*N pixels.
// A padding beat inside a frame is dropped. The line store is a single
// {upper, lower} RAM of MAX_SIDE entries with one read and one write per
// clock; it needs no clearing after reset. Writing side_length restarts the
// frame and must only happen while the block is idle. req_stall rises only
// when the result register is full and stalled.
// ----------------------------------------------------------------------------
`default_nettype none

module local_mean_threshold_3x3 #(
   parameter int MAX_SIDE   = 4096,
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                            clock,
   input  wire logic                            reset,
   // pixel beats
   input  wire logic                            req_valid,
   output      logic                            req_stall,
   input  wire logic [PIXEL_BITS-1:0]           req_pixel,
   input  wire logic                            req_padding,
   // result beats
   output      logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   output      logic                            rsp_above_mean,
   output      logic                            rsp_frame_end,
   // register port
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lmt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [lmt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   output      logic [lmt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   output      logic                            csr_pready
);

   import lmt_pkg::*;

   localparam int N_W   = $clog2(MAX_SIDE + 1);
   localparam int IDX_W = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int ROW_W = $clog2(MAX_SIDE + 2);

   logic [N_W-1:0]   side_n;
   logic             restart;
   logic [IDX_W-1:0] col_ff;
   logic [ROW_W-1:0] row_ff;
   logic [IDX_W-1:0] n_m1;
   logic             drain;
   logic             bubble;
   logic             final_beat;
   logic             in_valid;
   logic             in_ready;
   logic             take;
   lmt_ctl_type      ctl;

   lmt_csr #(
      .MAX_SIDE (MAX_SIDE)
   ) u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .side_n      (side_n),
      .restart     (restart)
   );

   // classify the beat by its input raster position
   assign n_m1       = IDX_W'(side_n - N_W'(1));
   assign drain      = 32'(row_ff) >= 32'(side_n);
   assign bubble     = req_padding && !drain;
   assign final_beat = (32'(row_ff) == 32'(side_n) + 1) && (col_ff == '0);
   assign ctl.drain  = drain;
   assign ctl.emit   = (row_ff > ROW_W'(1)) || ((row_ff == ROW_W'(1)) && (col_ff != '0));

   assign in_valid  = req_valid && !bubble;
   assign req_stall = !in_ready;
   assign take      = in_valid && in_ready;

   // advance the input position; wrap to the frame start after the final beat
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         col_ff <= '0;
         row_ff <= '0;
      end else if (take) begin
         if (final_beat) begin
            col_ff <= '0;
            row_ff <= '0;
         end else if (col_ff == n_m1) begin
            col_ff <= '0;
            row_ff <= row_ff + ROW_W'(1);
         end else begin
            col_ff <= col_ff + IDX_W'(1);
         end
      end
   end

   lmt_window #(
      .MAX_SIDE   (MAX_SIDE),
      .PIXEL_BITS (PIXEL_BITS)
   ) u_window (
      .clock          (clock),
      .reset          (reset),
      .restart        (restart),
      .side_n         (side_n),
      .in_valid       (in_valid),
      .in_col         (col_ff),
      .in_pix         (req_pixel),
      .in_ctl         (ctl),
      .in_ready       (in_ready),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_above_mean (rsp_above_mean),
      .rsp_frame_end  (rsp_frame_end)
   );

endmodule

`default_nettype wire

// ===== rtl/lmt_ram.sv =====
// ----------------------------------------------------------------------------
// lmt_ram
// Generic single-port-write, single-port-read RAM with registered read data.
// Read data holds while no read is issued.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 4096
) (
   input  wire logic                                   clock,
   input  wire logic                                   wr_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]                       wr_data,
   input  wire logic                                   rd_en,
   input  wire logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output      logic [WIDTH-1:0]                       rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // registered read port
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

`default_nettype wire

// ===== rtl/lmt_csr.sv =====
// ----------------------------------------------------------------------------
// lmt_csr
// APB-style register port. Holds side_length, clamps it to the supported
// image side and pulses a frame restart on every write of the register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_csr #(
   parameter int MAX_SIDE = 4096
) (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire logic                               csr_psel,
   input  wire logic                               csr_penable,
   input  wire logic                               csr_pwrite,
   input  wire logic [lmt_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  wire logic [lmt_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output      logic [lmt_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output      logic                               csr_pready,
   output      logic [$clog2(MAX_SIDE+1)-1:0]      side_n,
   output      logic                               restart
);

   import lmt_pkg::*;

   localparam int N_W     = $clog2(MAX_SIDE + 1);
   localparam int N_RESET = (SIDE_RESET > MAX_SIDE) ? MAX_SIDE : SIDE_RESET;

   logic              sel_side;
   logic              wr_side;
   logic [SIDE_W-1:0] side_ff;
   logic [SIDE_W-1:0] side_in;
   logic [N_W-1:0]    n_ff;
   logic [N_W-1:0]    n_in;

   // decode a completed write to side_length
   assign sel_side = (csr_paddr[2] == REG_SIDE_LENGTH);
   assign wr_side  = csr_psel && csr_penable && csr_pwrite && csr_pready && sel_side;

   // clamp the written side to 1..MAX_SIDE
   always_comb begin
      side_in = csr_pwdata[SIDE_W-1:0];
      if (side_in == '0) begin
         n_in = N_W'(1);
      end else if (32'(side_in) > MAX_SIDE) begin
         n_in = N_W'(MAX_SIDE);
      end else begin
         n_in = N_W'(side_in);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         side_ff <= SIDE_W'(SIDE_RESET);
         n_ff    <= N_W'(N_RESET);
      end else if (wr_side) begin
         side_ff <= side_in;
         n_ff    <= n_in;
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = sel_side ? CSR_DATA_W'(side_ff) : '0;
   assign side_n     = n_ff;
   assign restart    = wr_side;

endmodule

`default_nettype wire

// ===== rtl/lmt_window.sv =====
// ----------------------------------------------------------------------------
// lmt_window
// Line store memory and window stage. A beat reads its column of the line
// store, then shifts the 3x3 window, writes the column back one row down and
// tests center * count > sum over the clipped neighbourhood into the result
// register.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_window #(
   parameter int MAX_SIDE   = 4096,
   parameter int PIXEL_BITS = 8
) (
   input  wire logic                                          clock,
   input  wire logic                                          reset,
   input  wire logic                                          restart,
   input  wire logic [$clog2(MAX_SIDE+1)-1:0]                 side_n,
   input  wire logic                                          in_valid,
   input  wire logic [((MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1)-1:0] in_col,
   input  wire logic [PIXEL_BITS-1:0]                         in_pix,
   input  wire lmt_pkg::lmt_ctl_type                          in_ctl,
   output      logic                                          in_ready,
   output      logic                                          rsp_valid,
   input  wire logic                                          rsp_stall,
   output      logic                                          rsp_above_mean,
   output      logic                                          rsp_frame_end
);

   import lmt_pkg::*;

   localparam int N_W    = $clog2(MAX_SIDE + 1);
   localparam int IDX_W  = (MAX_SIDE > 1) ? $clog2(MAX_SIDE) : 1;
   localparam int LINE_W = 2 * PIXEL_BITS;
   localparam int SUM_W  = PIXEL_BITS + 4;

   // window stage registers
   logic                  s1_valid_ff;
   logic [PIXEL_BITS-1:0] s1_pix_ff;
   lmt_ctl_type           s1_ctl_ff;
   logic [IDX_W-1:0]      s1_addr_ff;
   logic                  s1_fwd_ff;
   logic [LINE_W-1:0]     fwd_data_ff;

   // window, [column: left, mid, right][row: top, mid, bottom]
   logic [PIXEL_BITS-1:0] win_ff [3][3];
   logic [PIXEL_BITS-1:0] win_in [3][3];

   // output raster position
   logic [IDX_W-1:0]      out_row_ff;
   logic [IDX_W-1:0]      out_col_ff;

   // result register
   logic                  rsp_valid_ff;
   logic                  above_ff;
   logic                  end_ff;

   logic                  out_ready;
   logic                  s1_go;
   logic                  take;
   logic                  wr_en;
   logic [LINE_W-1:0]     wr_data;
   logic [LINE_W-1:0]     rd_data;
   logic [LINE_W-1:0]     line;
   logic [IDX_W-1:0]      n_m1;
   logic                  last;
   logic [2:0]            col_ok;
   logic [2:0]            row_ok;
   logic [SUM_W-1:0]      sum;
   logic [3:0]            cnt;
   logic [SUM_W-1:0]      prod;
   logic                  above;

   // handshake: the window stage moves when the result register can take a beat
   assign out_ready = !rsp_valid_ff || !rsp_stall;
   assign s1_go     = s1_valid_ff && out_ready;
   assign in_ready  = !s1_valid_ff || s1_go;
   assign take      = in_valid && in_ready;

   // line store: {upper, lower} per column
   assign line    = s1_fwd_ff ? fwd_data_ff : rd_data;
   assign wr_en   = s1_go && !s1_ctl_ff.drain;
   assign wr_data = {line[PIXEL_BITS-1:0], s1_pix_ff};

   lmt_ram #(
      .WIDTH (LINE_W),
      .DEPTH (MAX_SIDE)
   ) u_line_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (s1_addr_ff),
      .wr_data (wr_data),
      .rd_en   (take),
      .rd_addr (in_col),
      .rd_data (rd_data)
   );

   // load the window stage; forward the column written in the same cycle
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (take) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_go) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         s1_pix_ff   <= in_pix;
         s1_ctl_ff   <= in_ctl;
         s1_addr_ff  <= in_col;
         s1_fwd_ff   <= wr_en && (s1_addr_ff == in_col);
         fwd_data_ff <= wr_data;
      end
   end

   // shift the window left and bring in the new column
   always_comb begin
      for (int k = 0; k < 3; k++) begin
         win_in[0][k] = win_ff[1][k];
         win_in[1][k] = win_ff[2][k];
      end
      win_in[2][0] = line[LINE_W-1:PIXEL_BITS];
      win_in[2][1] = line[PIXEL_BITS-1:0];
      win_in[2][2] = s1_ctl_ff.drain ? '0 : s1_pix_ff;
   end

   // clip the neighbourhood at the image borders
   assign n_m1   = IDX_W'(side_n - N_W'(1));
   assign col_ok = {out_col_ff != n_m1, 1'b1, out_col_ff != '0};
   assign row_ok = {out_row_ff != n_m1, 1'b1, out_row_ff != '0};
   assign last   = (out_row_ff == n_m1) && (out_col_ff == n_m1);

   // sum and count over the clipped window, then the exact mean test
   always_comb begin
      sum = '0;
      cnt = '0;
      for (int i = 0; i < 3; i++) begin
         for (int k = 0; k < 3; k++) begin
            if (col_ok[i] && row_ok[k]) begin
               sum = sum + SUM_W'(win_in[i][k]);
               cnt = cnt + 4'd1;
            end
         end
      end
      prod  = SUM_W'(SUM_W'(win_in[1][1]) * SUM_W'(cnt));
      above = prod > sum;
   end

   // window: clear on restart and after the frame's last result
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[i][k] <= '0;
            end
         end
      end else if (s1_go) begin
         for (int i = 0; i < 3; i++) begin
            for (int k = 0; k < 3; k++) begin
               win_ff[i][k] <= (s1_ctl_ff.emit && last) ? '0 : win_in[i][k];
            end
         end
      end
   end

   // advance the output raster position
   always_ff @(posedge clock) begin
      if (reset || restart) begin
         out_row_ff <= '0;
         out_col_ff <= '0;
      end else if (s1_go && s1_ctl_ff.emit) begin
         if (last) begin
            out_row_ff <= '0;
            out_col_ff <= '0;
         end else if (out_col_ff == n_m1) begin
            out_row_ff <= out_row_ff + IDX_W'(1);
            out_col_ff <= '0;
         end else begin
            out_col_ff <= out_col_ff + IDX_W'(1);
         end
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_go) begin
         rsp_valid_ff <= s1_ctl_ff.emit;
      end else if (out_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_go && s1_ctl_ff.emit) begin
         above_ff <= above;
         end_ff   <= last;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_above_mean = above_ff;
   assign rsp_frame_end  = end_ff;

endmodule

`default_nettype wire

// ===== rtl/lmt_checker.sv =====
// ----------------------------------------------------------------------------
// lmt_checker
// Port-level checks of the local mean threshold block, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module lmt_checker (
   input  wire logic                            clock,
   input  wire logic                            reset,
   input  wire logic                            req_valid,
   input  wire logic                            req_stall,
   input  wire logic                            rsp_valid,
   input  wire logic                            rsp_stall,
   input  wire logic                            rsp_above_mean,
   input  wire logic                            rsp_frame_end,
   input  wire logic                            csr_psel,
   input  wire logic                            csr_penable,
   input  wire logic                            csr_pwrite,
   input  wire logic [lmt_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input  wire logic [lmt_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input  wire logic [lmt_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input  wire logic                            csr_pready
);

   import lmt_pkg::*;

   logic side_write;

   assign side_write = csr_psel && csr_penable && csr_pwrite && csr_pready &&
                       (csr_paddr[2] == REG_SIDE_LENGTH);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_above_mean) &&
                                 $stable(rsp_frame_end))
      else $error("result beat changed while stalled");

   // an empty result register never backs up the pixel stream
   a_no_false_stall: assert property (@(posedge clock) disable iff (reset)
      !rsp_valid |-> !req_stall)
      else $error("pixel stream stalled with no result pending");

   // side_length reads back what was written
   a_side_readback: assert property (@(posedge clock) disable iff (reset)
      side_write |=> (csr_paddr[2] != REG_SIDE_LENGTH) ||
                     (csr_prdata == CSR_DATA_W'($past(csr_pwdata[SIDE_W-1:0]))))
      else $error("side_length readback mismatch");

   // no result beat right after reset
   a_reset_empty: assert property (@(posedge clock)
      !reset && $past(reset) |-> !rsp_valid)
      else $error("result beat present after reset");

endmodule

bind local_mean_threshold_3x3 lmt_checker u_lmt_checker (.*);

`default_nettype wire

// ===== sim/local_mean_threshold_3x3_tb.sv =====
// ----------------------------------------------------------------------------
// local_mean_threshold_3x3_tb
// Self-checking bench for the 3x3 local mean threshold block.
// ----------------------------------------------------------------------------
// Streams square images through the pixel channel while a scoreboard
// predicts each result bit. The scoreboard keeps its own line stores,
// window and raster counters. A small directed part covers the one-pixel,
// 2x2 and 3x3 images, bubbles and pixels sent while draining. A short
// partial frame at the widest side checks that the clamped side gives no
// early result. Random frames of small sides follow, with random bubbles,
// truncated frames and register rewrites between phases. Both channels idle
// at random, except for one calm stretch.
// ----------------------------------------------------------------------------

typedef struct packed {
   logic above_mean;
   logic frame_end;
} threshold_verdict_type;

class threshold_scoreboard;
   localparam int MAX_SIDE = 4096;

   bit [12:0]             side_reg;
   bit [7:0]              upper_line [MAX_SIDE];
   bit [7:0]              lower_line [MAX_SIDE];
   bit [7:0]              win [3][3];   // [column: left, mid, right][row: top, mid, bottom]
   int unsigned           in_row;
   int unsigned           in_col;
   longint unsigned       out_pos;
   threshold_verdict_type verdicts [$];
   int                    errors;
   int                    checked;

   function new();
      side_reg = 13'd2000;
      errors   = 0;
      checked  = 0;
      restart();
   endfunction

   // clear window and positions; line stores keep their contents
   function void restart();
      foreach (win[c, r]) win[c][r] = 8'd0;
      in_row  = 0;
      in_col  = 0;
      out_pos = 0;
   endfunction

   function void write_side(bit [12:0] value);
      side_reg = value;
      restart();
   endfunction

   function int pending();
      return verdicts.size();
   endfunction

   // advance the raster for one accepted beat and queue the result it causes
   function void note_beat(bit [7:0] pix, bit pad);
      int unsigned           n;
      int unsigned           j;
      int unsigned           sum;
      int unsigned           count;
      longint unsigned       total;
      longint unsigned       p;
      longint unsigned       q;
      longint unsigned       r;
      longint unsigned       c;
      bit                    draining;
      threshold_verdict_type v;

      n = (side_reg == 0) ? 1 : ((side_reg > MAX_SIDE) ? MAX_SIDE : side_reg);
      total    = longint'(n) * n;
      p        = longint'(in_row) * n + in_col;
      draining = (p >= total);

      // drop bubbles inside the frame
      if (!draining && pad) return;

      // shift the window left and load the new column
      j = in_col;
      for (int k = 0; k < 3; k++) begin
         win[0][k] = win[1][k];
         win[1][k] = win[2][k];
      end
      win[2][0] = upper_line[j];
      win[2][1] = lower_line[j];
      win[2][2] = draining ? 8'd0 : pix;
      if (!draining) begin
         upper_line[j] = lower_line[j];
         lower_line[j] = pix;
      end

      in_col++;
      if (in_col >= n) begin
         in_col = 0;
         in_row++;
      end

      // results lag by one row plus one pixel
      if (p < n + 1) return;

      q     = out_pos;
      r     = q / n;
      c     = q % n;
      sum   = 0;
      count = 0;
      for (int dc = -1; dc <= 1; dc++) begin
         if ((dc < 0 && c == 0) || (dc > 0 && c + 1 >= n)) continue;
         for (int dr = -1; dr <= 1; dr++) begin
            if ((dr < 0 && r == 0) || (dr > 0 && r + 1 >= n)) continue;
            sum += win[dc + 1][dr + 1];
            count++;
         end
      end

      v.above_mean = (win[1][1] * count > sum);
      v.frame_end  = (q + 1 >= total);
      verdicts.push_back(v);
      out_pos++;
      if (v.frame_end) restart();
   endfunction

   task report(string msg);
      errors++;
      if (errors <= 50) $display("MISMATCH: %s", msg);
   endtask

   // compare one result beat with the oldest prediction
   task check_result(logic above, logic fend);
      threshold_verdict_type v;
      if (verdicts.size() == 0) begin
         report($sformatf("result with nothing predicted: above_mean=%b frame_end=%b",
                          above, fend));
         return;
      end
      v = verdicts.pop_front();
      if (above !== v.above_mean)
         report($sformatf("result %0d: above_mean=%b, predicted %b",
                          checked, above, v.above_mean));
      if (fend !== v.frame_end)
         report($sformatf("result %0d: frame_end=%b, predicted %b",
                          checked, fend, v.frame_end));
      checked++;
   endtask
endclass

module local_mean_threshold_3x3_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MAX_SIDE      = 4096;
   localparam int PIXEL_BITS    = 8;
   localparam int SETTLE_CYCLES = 8;
   localparam int TAIL_CYCLES   = 16;
   localparam int QUIET_LIMIT   = 2000;
   localparam int RANDOM_ITEMS  = 360;
   localparam int WIDE_BEATS    = 32;
   localparam int CALM_START    = 100;
   localparam int CALM_ITEMS    = 150;
   localparam int IDLE_PCT      = 25;
   localparam int BUBBLE_PCT    = 8;
   localparam logic [lmt_pkg::CSR_ADDR_W-1:0] SIDE_ADDR =
      lmt_pkg::CSR_ADDR_W'({lmt_pkg::REG_SIDE_LENGTH, 2'b00});

   typedef enum {PIX_UNIFORM, PIX_FLAT, PIX_EXTREME, PIX_NEAR} pix_mode_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                            req_valid   = 1'b0;
   logic                            req_stall;
   logic [PIXEL_BITS-1:0]           req_pixel   = '0;
   logic                            req_padding = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall   = 1'b0;
   logic                            rsp_above_mean;
   logic                            rsp_frame_end;
   logic                            csr_psel    = 1'b0;
   logic                            csr_penable = 1'b0;
   logic                            csr_pwrite  = 1'b0;
   logic [lmt_pkg::CSR_ADDR_W-1:0]  csr_paddr   = '0;
   logic [lmt_pkg::CSR_DATA_W-1:0]  csr_pwdata  = '0;
   logic [lmt_pkg::CSR_DATA_W-1:0]  csr_prdata;
   logic                            csr_pready;

   int gap_pct       = IDLE_PCT;
   int stall_pct     = IDLE_PCT;
   int quiet_cycles  = 0;
   int counted_items = 0;

   threshold_scoreboard sb = new();

   local_mean_threshold_3x3 #(
      .MAX_SIDE   (MAX_SIDE),
      .PIXEL_BITS (PIXEL_BITS)
   ) dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_pixel      (req_pixel),
      .req_padding    (req_padding),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_above_mean (rsp_above_mean),
      .rsp_frame_end  (rsp_frame_end),
      .csr_psel       (csr_psel),
      .csr_penable    (csr_penable),
      .csr_pwrite     (csr_pwrite),
      .csr_paddr      (csr_paddr),
      .csr_pwdata     (csr_pwdata),
      .csr_prdata     (csr_prdata),
      .csr_pready     (csr_pready)
   );

   // 8 ns clock
   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   // check result beats and stall the result channel at random
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_above_mean, rsp_frame_end);
         rsp_stall <= ($urandom_range(0, 99) < stall_pct);
      end
   end

   // end the run when nothing moves for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
         $display("local_mean_threshold_3x3_tb: done, errors");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   function automatic logic [7:0] draw_pixel(pix_mode_type mode, logic [7:0] base);
      case (mode)
         PIX_FLAT:    return ($urandom_range(0, 7) == 0) ? base + 8'd1 : base;
         PIX_EXTREME: return ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
         PIX_NEAR:    return base + 8'($urandom_range(0, 3));
         default:     return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // offer one pixel beat after a random gap; hold it until accepted
   task automatic send_beat(input logic [7:0] pix, input logic pad);
      while ($urandom_range(0, 99) < gap_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_pixel   <= pix;
      req_padding <= pad;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.note_beat(pix, pad);
   endtask

   // drop valid, wait for every predicted result, then let the pipeline empty
   task automatic settle();
      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input logic write, input logic [31:0] data,
                             output logic [31:0] rdata);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= write;
      csr_paddr   <= SIDE_ADDR;
      csr_pwdata  <= data;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      while (!csr_pready) @(posedge clock);
      rdata        = csr_prdata;
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
   endtask

   // write side_length, then read it back
   task automatic set_side(input logic [31:0] data);
      logic [31:0] readback;
      csr_access(1'b1, data, readback);
      sb.write_side(data[lmt_pkg::SIDE_W-1:0]);
      @(posedge clock);
      csr_access(1'b0, '0, readback);
      if (readback !== 32'(data[lmt_pkg::SIDE_W-1:0]))
         sb.report($sformatf("side_length read %0d after writing %0d",
                             readback, data[lmt_pkg::SIDE_W-1:0]));
   endtask

   // one frame of side n plus its drain, optionally cut short
   task automatic run_frame(input int n, input pix_mode_type mode, input int bubble_pct,
                            input int stop_after);
      int          beats;
      logic [7:0]  base;
      base  = 8'($urandom_range(0, 252));
      beats = n * n + n + 1;
      for (int k = 0; k < beats && (stop_after < 0 || k < stop_after); k++) begin
         if (k < n * n) begin
            while ($urandom_range(0, 99) < bubble_pct)
               send_beat(8'($urandom_range(0, 255)), 1'b1);
            send_beat(draw_pixel(mode, base), 1'b0);
         end else begin
            send_beat(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
         end
         counted_items++;
      end
   endtask

   initial begin
      logic [31:0] readback;
      logic [31:0] side_word;
      logic [7:0]  square2 [4];
      logic [7:0]  square3 [9];
      int          n;
      int          frames;
      int          stop_at;
      int          calm_end;
      bit          calm;

      square2 = '{8'hFF, 8'h00, 8'h00, 8'h00};
      square3 = '{8'h00, 8'hFF, 8'h0A, 8'h0A, 8'h0A, 8'h0A, 8'hFF, 8'h00, 8'hFF};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // side_length comes out of reset at its default
      csr_access(1'b0, '0, readback);
      if (readback !== 32'(lmt_pkg::SIDE_RESET))
         sb.report($sformatf("side_length reads %0d after reset", readback));
      @(posedge clock);

      // side 0 clamps to a one-pixel image: bubble, pixel, pixel during drain
      set_side(32'd0);
      send_beat(8'd200, 1'b1);
      send_beat(8'hFF, 1'b0);
      send_beat(8'h5A, 1'b0);
      send_beat(8'h00, 1'b1);
      settle();

      // 2x2: every window is the whole image
      set_side(32'd2);
      foreach (square2[i]) send_beat(square2[i], 1'b0);
      repeat (3) send_beat(8'h00, 1'b1);
      settle();

      // 3x3: corners, edges, the full window and equal neighbors
      set_side(32'd3);
      foreach (square3[i]) send_beat(square3[i], 1'b0);
      send_beat(8'hFF, 1'b0);
      repeat (3) send_beat(8'h00, 1'b1);
      settle();

      // all side bits set clamps to the widest image; a short start gives no result
      set_side(32'h0000_1FFF);
      run_frame(MAX_SIDE, PIX_UNIFORM, 0, WIDE_BEATS);
      settle();

      // random phases of small images
      counted_items = 0;
      calm_end      = 0;
      while (counted_items < RANDOM_ITEMS) begin
         if (calm_end == 0 && counted_items >= CALM_START)
            calm_end = counted_items + CALM_ITEMS;
         calm      = (calm_end != 0) && (counted_items < calm_end);
         gap_pct   = calm ? 0 : IDLE_PCT;
         stall_pct = calm ? 0 : IDLE_PCT;

         case ($urandom_range(0, 19))
            0:       side_word = 32'd0;
            1, 2, 3: side_word = $urandom_range(7, 12);
            default: side_word = $urandom_range(1, 6);
         endcase
         n = (side_word == 0) ? 1 : side_word;
         if ($urandom_range(0, 1) == 1)
            side_word |= $urandom() & ~32'((1 << lmt_pkg::SIDE_W) - 1);
         set_side(side_word);

         frames = (n > 6) ? 1 : $urandom_range(1, 3);
         for (int f = 0; f < frames; f++) begin
            stop_at = -1;
            if (f == frames - 1 && $urandom_range(0, 7) == 0)
               stop_at = $urandom_range(1, n * n + n);
            run_frame(n, pix_mode_type'($urandom_range(0, 3)), BUBBLE_PCT, stop_at);
         end
         settle();
      end

      repeat (TAIL_CYCLES) @(posedge clock);
      if (sb.errors == 0 && sb.pending() == 0) begin
         $display("local_mean_threshold_3x3_tb: done, clean");
      end else begin
         $display("local_mean_threshold_3x3_tb: done, errors");
      end
      $finish;
   end

endmodule
